FILE: src/olie_pkg.sv
`default_nettype none

package olie_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_ERASE  = 2'd1;
	localparam logic [1:0] MODE_MOVE   = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] read_value;
		logic [CNT_W-1:0] entry_count;
		logic             range_error;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic [1:0] mode;
		logic       err;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} status_t;

endpackage

`default_nettype wire

FILE: src/olie_ctrl.sv
`default_nettype none

module olie_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire olie_pkg::req_t   req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output olie_pkg::cmd_t        cmd,
	input  wire olie_pkg::status_t status
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;
	logic first_ok;
	logic second_ok;
	logic room;

	assign first_ok  = olie_pkg::CNT_W'(req.first_index) < status.count;
	assign second_ok = olie_pkg::CNT_W'(req.second_index) < status.count;
	assign room      = status.count < olie_pkg::CNT_W'(olie_pkg::LIST_DEPTH);

	// result slot frees as it is taken, so a new beat can enter the same cycle
	assign req_ready = (state_q == ST_EMPTY) || rsp_ready;
	assign rsp_valid = (state_q == ST_FULL);

	always_comb begin
		cmd.load = req_valid && req_ready;
		cmd.mode = req.mode;
		case (req.mode)
			olie_pkg::MODE_APPEND: cmd.err = !room;
			olie_pkg::MODE_ERASE:  cmd.err = !first_ok;
			olie_pkg::MODE_MOVE:   cmd.err = !(first_ok && second_ok);
			olie_pkg::MODE_READ:   cmd.err = !first_ok;
			default:               cmd.err = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		if (cmd.load) begin
			state_d = ST_FULL;
		end else if (rsp_ready) begin
			state_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> rsp_valid)
		else $error("accepted beat did not produce a result");

	a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !cmd.load)
		else $error("beat taken while result stalled");

	a_append_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		(req.mode == olie_pkg::MODE_APPEND
			&& status.count == olie_pkg::CNT_W'(olie_pkg::LIST_DEPTH)) |-> cmd.err)
		else $error("append to full list not flagged");

endmodule

`default_nettype wire

FILE: src/olie_datapath.sv
`default_nettype none

module olie_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire olie_pkg::req_t req,
	input  wire olie_pkg::cmd_t cmd,
	output olie_pkg::status_t   status,
	output olie_pkg::rsp_t      rsp
);

	logic [olie_pkg::IDX_W-1:0] list_q [olie_pkg::LIST_DEPTH];
	logic [olie_pkg::IDX_W-1:0] list_d [olie_pkg::LIST_DEPTH];
	logic [olie_pkg::IDX_W-1:0] prv    [olie_pkg::LIST_DEPTH];
	logic [olie_pkg::IDX_W-1:0] nxt    [olie_pkg::LIST_DEPTH];
	logic [olie_pkg::CNT_W-1:0] count_q;
	logic [olie_pkg::CNT_W-1:0] count_d;
	logic [olie_pkg::IDX_W-1:0] held;
	logic [olie_pkg::IDX_W-1:0] value;
	logic [olie_pkg::IDX_W-1:0] src_val;
	logic [olie_pkg::IDX_W-1:0] kk;
	logic [olie_pkg::IDX_W-1:0] a;
	logic [olie_pkg::IDX_W-1:0] b;
	logic                       seen;
	logic                       hit;
	olie_pkg::rsp_t             rsp_q;

	assign a = req.first_index;
	assign b = req.second_index;
	assign held = list_q[a];
	assign status.count = count_q;
	assign rsp = rsp_q;

	// neighbour taps for the shifting cells
	always_comb begin
		for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
			prv[k] = (k == 0) ? list_q[k] : list_q[(k == 0) ? 0 : k - 1];
			nxt[k] = (k == olie_pkg::LIST_DEPTH - 1) ? list_q[k]
				: list_q[(k == olie_pkg::LIST_DEPTH - 1) ? k : k + 1];
		end
	end

	always_comb begin
		for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
			list_d[k] = list_q[k];
		end
		count_d = count_q;
		value   = '0;
		seen    = 1'b0;
		kk      = '0;
		hit     = 1'b0;
		src_val = '0;
		case (cmd.mode)
			olie_pkg::MODE_APPEND: begin
				if (!cmd.err) begin
					list_d[count_q[olie_pkg::IDX_W-1:0]] = count_q[olie_pkg::IDX_W-1:0];
					count_d = count_q + olie_pkg::CNT_W'(1);
				end
			end
			olie_pkg::MODE_ERASE: begin
				// cells at or past the erased entry close the gap from above
				for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
					hit = (list_q[k] == a)
						&& (olie_pkg::CNT_W'(k) < count_q);
					seen = seen | hit;
					src_val = seen ? nxt[k] : list_q[k];
					if (src_val > a) begin
						src_val = src_val - olie_pkg::IDX_W'(1);
					end
					list_d[k] = src_val;
				end
				if (!cmd.err) begin
					count_d = count_q - olie_pkg::CNT_W'(1);
				end else begin
					for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
						list_d[k] = list_q[k];
					end
				end
			end
			olie_pkg::MODE_MOVE: begin
				if (!cmd.err) begin
					for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
						kk = olie_pkg::IDX_W'(k);
						if (a > b && kk > b && kk <= a) begin
							list_d[k] = prv[k];
						end else if (a < b && kk >= a && kk < b) begin
							list_d[k] = nxt[k];
						end
						if (kk == b) begin
							list_d[k] = held;
						end
					end
				end
			end
			olie_pkg::MODE_READ: begin
				if (!cmd.err) begin
					value = held;
				end
			end
			default: begin
				value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.read_value  <= value;
			rsp_q.entry_count <= count_d;
			rsp_q.range_error <= cmd.err;
			if (!cmd.err) begin
				for (int k = 0; k < olie_pkg::LIST_DEPTH; k++) begin
					list_q[k] <= list_d[k];
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olie_pkg::CNT_W'(olie_pkg::LIST_DEPTH))
		else $error("entry count beyond depth");

	a_erase_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.err && cmd.mode == olie_pkg::MODE_ERASE)
		|=> count_q == $past(count_q) - olie_pkg::CNT_W'(1))
		else $error("erase did not lower count");

	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.err) |=> (count_q == $past(count_q) && rsp_q.range_error
			&& rsp_q.read_value == '0))
		else $error("failed operation changed state or value");

endmodule

`default_nettype wire

FILE: src/ordered_index_list_engine.sv
// an accepted beat has its result valid from the next cycle; one beat per
// cycle unless rsp_ready stalls, all list cells shift or compare in parallel
// the single result register frees in the cycle its beat is taken
// reset: arst_n clears the entry count and the result slot; list cells hold
// no reset value and are only read below the entry count
`default_nettype none

module ordered_index_list_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire olie_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output olie_pkg::rsp_t      rsp
);

	olie_pkg::cmd_t    cmd;
	olie_pkg::status_t status;

	olie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.status    (status)
	);

	olie_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
